/* sv/ufe_pkg.sv */
// Shared types and constants for the union-find spanning-tree edge filter.
package ufe_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NCOUNT_W = NODE_W + 1;
    localparam int ID_W = 16;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = NCOUNT_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_WALK_B,
        ST_LINK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   edge_id;
        logic              in_tree;
        logic              tree_complete;
        logic [NODE_W-1:0] accepted_total;
    } result_t;

endpackage

/* sv/kruskal_union_find_edge_filter.sv */
// Top level of the union-find spanning-tree edge filter with configuration and output registers.
//
// Edges are taken one at a time, each word giving an edge id and two end vertices, and each
// yields exactly one result word. An examined edge walks each end up the parent memory to its
// root and, when the roots differ, links them so that the edge becomes a tree edge; an edge that
// is not examined goes straight to its result. After reset, and for every word with new_graph
// set, the parent memory is swept back to identity before that edge is examined; no word is taken
// during the sweep, while configuration writes are taken at any time.
module kruskal_union_find_edge_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ufe_pkg::NCOUNT_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ufe_pkg::ID_W-1:0]     edge_id,
    input  logic [ufe_pkg::NODE_W-1:0]   end_a,
    input  logic [ufe_pkg::NODE_W-1:0]   end_b,
    input  logic                         new_graph,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ufe_pkg::ID_W-1:0]     edge_id_out,
    output logic                         in_tree,
    output logic                         tree_complete,
    output logic [ufe_pkg::NODE_W-1:0]   accepted_total
);

    logic [ufe_pkg::NCOUNT_W-1:0] node_count_reg;
    logic                         out_valid_reg;
    ufe_pkg::result_t             out_reg;
    ufe_pkg::result_t             res;
    logic                         res_valid;
    logic                         res_ready;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    ufe_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (node_count_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .edge_id    (edge_id),
        .end_a      (end_a),
        .end_b      (end_b),
        .new_graph  (new_graph),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ufe_pkg::NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_id_out    = out_reg.edge_id;
    assign in_tree        = out_reg.in_tree;
    assign tree_complete  = out_reg.tree_complete;
    assign accepted_total = out_reg.accepted_total;

endmodule

/* sv/ufe_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
module ufe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ufe_engine.sv */
// Union-find sequencer: clears the parent memory, walks both ends to their roots and links them.
module ufe_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ufe_pkg::NCOUNT_W-1:0]   node_count,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ufe_pkg::ID_W-1:0]       edge_id,
    input  logic [ufe_pkg::NODE_W-1:0]     end_a,
    input  logic [ufe_pkg::NODE_W-1:0]     end_b,
    input  logic                           new_graph,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ufe_pkg::result_t               res
);

    ufe_pkg::state_t state_reg, state_next;

    logic [ufe_pkg::NODE_W-1:0]   clr_reg, clr_next;
    logic                         pend_reg, pend_next;
    logic [ufe_pkg::NODE_W-1:0]   count_reg, count_next;
    logic                         complete_reg, complete_next;
    logic                         taken_reg, taken_next;
    logic [ufe_pkg::ID_W-1:0]     id_reg, id_next;
    logic [ufe_pkg::NODE_W-1:0]   a_reg, a_next;
    logic [ufe_pkg::NODE_W-1:0]   b_reg, b_next;
    logic [ufe_pkg::NODE_W-1:0]   node_reg, node_next;
    logic [ufe_pkg::NODE_W-1:0]   ra_reg, ra_next;

    logic                         mem_we;
    logic [ufe_pkg::NODE_W-1:0]   mem_waddr;
    logic [ufe_pkg::NODE_W-1:0]   mem_wdata;
    logic [ufe_pkg::NODE_W-1:0]   mem_raddr;
    logic [ufe_pkg::NODE_W-1:0]   mem_rdata;

    logic [ufe_pkg::NCOUNT_W-1:0] used_n;
    logic                         examine;
    logic                         at_root;
    logic                         in_fire;
    logic                         done_complete;

    ufe_ram #(
        .DEPTH(ufe_pkg::MAX_NODES),
        .WIDTH(ufe_pkg::NODE_W)
    ) u_parent_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        if (node_count == '0)
        begin
            used_n = ufe_pkg::NCOUNT_W'(1);
        end
        else if (node_count > ufe_pkg::NODE_COUNT_RESET)
        begin
            used_n = ufe_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            used_n = node_count;
        end
    end

    assign examine = !complete_reg && ({1'b0, a_reg} < used_n) && ({1'b0, b_reg} < used_n);
    assign at_root = (mem_rdata == node_reg);
    assign in_fire = in_valid && in_ready;
    assign done_complete = complete_reg ||
                           ({1'b0, count_reg} >= (used_n - ufe_pkg::NCOUNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ufe_pkg::ST_CLEAR:
            begin
                if (clr_reg == ufe_pkg::LAST_NODE)
                begin
                    state_next = pend_reg ? ufe_pkg::ST_CHECK : ufe_pkg::ST_IDLE;
                end
            end
            ufe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = new_graph ? ufe_pkg::ST_CLEAR : ufe_pkg::ST_CHECK;
                end
            end
            ufe_pkg::ST_CHECK:
            begin
                state_next = examine ? ufe_pkg::ST_WALK_A : ufe_pkg::ST_DONE;
            end
            ufe_pkg::ST_WALK_A:
            begin
                if (at_root)
                begin
                    state_next = ufe_pkg::ST_WALK_B;
                end
            end
            ufe_pkg::ST_WALK_B:
            begin
                if (at_root)
                begin
                    state_next = (ra_reg != node_reg) ? ufe_pkg::ST_LINK : ufe_pkg::ST_DONE;
                end
            end
            ufe_pkg::ST_LINK:
            begin
                state_next = ufe_pkg::ST_DONE;
            end
            ufe_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ufe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ufe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next      = clr_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        complete_next = complete_reg;
        taken_next    = taken_reg;
        id_next       = id_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        node_next     = node_reg;
        ra_next       = ra_reg;
        mem_we        = 1'b0;
        mem_waddr     = node_reg;
        mem_wdata     = node_reg;
        mem_raddr     = node_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        res.edge_id        = id_reg;
        res.in_tree        = taken_reg;
        res.tree_complete  = done_complete;
        res.accepted_total = count_reg;
        case (state_reg)
            ufe_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ufe_pkg::LAST_NODE)
                begin
                    pend_next = 1'b0;
                end
            end
            ufe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next    = edge_id;
                    a_next     = end_a;
                    b_next     = end_b;
                    taken_next = 1'b0;
                    if (new_graph)
                    begin
                        count_next    = '0;
                        complete_next = 1'b0;
                        pend_next     = 1'b1;
                    end
                end
            end
            ufe_pkg::ST_CHECK:
            begin
                mem_raddr = a_reg;
                node_next = a_reg;
            end
            ufe_pkg::ST_WALK_A:
            begin
                if (at_root)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = a_reg;
                    mem_wdata = node_reg;
                    ra_next   = node_reg;
                    mem_raddr = b_reg;
                    node_next = b_reg;
                end
                else
                begin
                    mem_raddr = mem_rdata;
                    node_next = mem_rdata;
                end
            end
            ufe_pkg::ST_WALK_B:
            begin
                if (at_root)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = b_reg;
                    mem_wdata = node_reg;
                end
                else
                begin
                    mem_raddr = mem_rdata;
                    node_next = mem_rdata;
                end
            end
            ufe_pkg::ST_LINK:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ra_reg;
                mem_wdata  = node_reg;
                taken_next = 1'b1;
                count_next = count_reg + 1'b1;
            end
            ufe_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    complete_next = done_complete;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ufe_pkg::ST_CLEAR;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
            taken_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
            taken_reg    <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        node_reg <= node_next;
        ra_reg   <= ra_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("A second word was taken while an edge was in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufe_pkg::ST_IDLE) |-> !mem_we)
        else $error("The parent memory was written while idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufe_pkg::ST_LINK) |-> (ra_reg != node_reg))
        else $error("A root was linked under itself.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.in_tree) |-> (res.accepted_total != '0))
        else $error("A tree edge was reported with a zero edge count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (complete_reg && !(in_fire && new_graph)) |=> complete_reg)
        else $error("The completion flag dropped without a new graph.");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the union-find spanning-tree edge filter.
module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_WORDS = 800;
    localparam int LONG_HOLD = 500;

    typedef struct packed {
        logic [ufe_pkg::ID_W-1:0]   id;
        logic [ufe_pkg::NODE_W-1:0] a;
        logic [ufe_pkg::NODE_W-1:0] b;
        logic                       fresh;
    } edge_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [ufe_pkg::NCOUNT_W-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [ufe_pkg::ID_W-1:0]     edge_id = '0;
    logic [ufe_pkg::NODE_W-1:0]   end_a = '0;
    logic [ufe_pkg::NODE_W-1:0]   end_b = '0;
    logic                         new_graph = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [ufe_pkg::ID_W-1:0]     edge_id_out;
    logic                         in_tree;
    logic                         tree_complete;
    logic [ufe_pkg::NODE_W-1:0]   accepted_total;

    edge_word_t                   edge_words[$];
    ufe_pkg::result_t             expected_verdicts[$];
    logic [ufe_pkg::NODE_W-1:0]   parent_of[ufe_pkg::MAX_NODES];
    logic [ufe_pkg::NODE_W-1:0]   tree_edges;
    logic                         tree_done;
    logic [ufe_pkg::NCOUNT_W-1:0] node_limit;
    edge_word_t                   next_word;
    ufe_pkg::result_t             due;
    int                           words_queued = 0;
    int                           words_taken = 0;
    int                           verdicts_seen = 0;
    int                           cfg_writes = 0;
    int                           fault_count = 0;
    int                           idle_cycles = 0;
    int                           send_gap = 0;
    int                           recv_gap = 0;
    int                           hold_left = 0;
    int                           holds_done = 0;
    bit                           steady = 1'b0;
    bit                           word_taken = 1'b0;

    kruskal_union_find_edge_filter u_top (.*);

    function automatic void clear_forest();
        for (int v = 0; v < ufe_pkg::MAX_NODES; v++)
            parent_of[v] = ufe_pkg::NODE_W'(v);
        tree_edges = '0;
        tree_done = 1'b0;
    endfunction

    function automatic int clamp_nodes(logic [ufe_pkg::NCOUNT_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > ufe_pkg::MAX_NODES)
            return ufe_pkg::MAX_NODES;
        return int'(setting);
    endfunction

    // The walk repoints only the vertex it started from.
    function automatic logic [ufe_pkg::NODE_W-1:0] root_of(logic [ufe_pkg::NODE_W-1:0] start);
        logic [ufe_pkg::NODE_W-1:0] node;
        node = start;
        for (int s = 0; s < ufe_pkg::MAX_NODES; s++)
        begin
            if (parent_of[node] == node)
                break;
            node = parent_of[node];
        end
        parent_of[start] = node;
        return node;
    endfunction

    function automatic ufe_pkg::result_t judge_edge(edge_word_t w);
        int                         span;
        logic [ufe_pkg::NODE_W-1:0] ra;
        logic [ufe_pkg::NODE_W-1:0] rb;
        ufe_pkg::result_t           r;
        span = clamp_nodes(node_limit);
        if (w.fresh)
            clear_forest();
        r.in_tree = 1'b0;
        if (!tree_done && int'(w.a) < span && int'(w.b) < span)
        begin
            ra = root_of(w.a);
            rb = root_of(w.b);
            if (ra != rb)
            begin
                parent_of[ra] = rb;
                tree_edges = tree_edges + 1'b1;
                r.in_tree = 1'b1;
            end
        end
        if (int'(tree_edges) >= span - 1)
            tree_done = 1'b1;
        r.edge_id = w.id;
        r.tree_complete = tree_done;
        r.accepted_total = tree_edges;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_edge(input int id, input int a, input int b, input bit fresh);
        edge_words.push_back({ufe_pkg::ID_W'(id), ufe_pkg::NODE_W'(a), ufe_pkg::NODE_W'(b),
                              fresh});
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [ufe_pkg::NCOUNT_W-1:0] value);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !word_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (edge_words.size() > 0)
            begin
                next_word = edge_words.pop_front();
                in_valid <= 1'b1;
                edge_id <= next_word.id;
                end_a <= next_word.a;
                end_b <= next_word.b;
                new_graph <= next_word.fresh;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (holds_done < 2 && verdicts_seen > 100 + 300 * holds_done
                 && edge_words.size() > 20)
        begin
            out_ready <= 1'b0;
            hold_left = LONG_HOLD;
            holds_done++;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        word_taken = rst_n && in_valid && in_ready;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            node_limit = cfg_data;
            cfg_writes++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("Result word arrived with no edge pending.");
                fault_count++;
            end
            else
            begin
                due = expected_verdicts.pop_front();
                if (edge_id_out !== due.edge_id)
                begin
                    $error("edge_id_out: expected %0d, got %0d", due.edge_id, edge_id_out);
                    fault_count++;
                end
                if (in_tree !== due.in_tree)
                begin
                    $error("in_tree: expected %0d, got %0d", due.in_tree, in_tree);
                    fault_count++;
                end
                if (tree_complete !== due.tree_complete)
                begin
                    $error("tree_complete: expected %0d, got %0d",
                           due.tree_complete, tree_complete);
                    fault_count++;
                end
                if (accepted_total !== due.accepted_total)
                begin
                    $error("accepted_total: expected %0d, got %0d",
                           due.accepted_total, accepted_total);
                    fault_count++;
                end
            end
            verdicts_seen++;
        end
        if (word_taken)
        begin
            expected_verdicts.push_back(judge_edge({edge_id, end_a, end_b, new_graph}));
            words_taken++;
        end
        if (word_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int                           target;
        int                           roll;
        int                           span;
        int                           graphs;
        int                           count;
        int                           base;
        int                           a;
        int                           b;
        bit                           chain;
        bit                           fresh;
        logic [ufe_pkg::NCOUNT_W-1:0] setting;

        clear_forest();
        node_limit = ufe_pkg::NODE_COUNT_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // An eight-vertex graph: a chain, a cycle, a self loop, each end in turn out of range,
        // then completion followed by an edge that must be turned away.
        write_node_count(11'd8);
        queue_edge(0, 0, 1, 1'b1);
        queue_edge(16'hFFFF, 1, 2, 1'b0);
        queue_edge(2, 2, 3, 1'b0);
        queue_edge(3, 0, 3, 1'b0);
        queue_edge(4, 4, 4, 1'b0);
        queue_edge(5, 8, 0, 1'b0);
        queue_edge(6, 0, 1023, 1'b0);
        queue_edge(7, 4, 5, 1'b0);
        queue_edge(8, 6, 7, 1'b0);
        queue_edge(9, 5, 7, 1'b0);
        queue_edge(10, 3, 7, 1'b0);
        queue_edge(11, 1, 6, 1'b0);
        wait_idle();

        // A node count of zero acts as a single vertex.
        write_node_count(11'd0);
        queue_edge(12, 0, 0, 1'b1);
        queue_edge(13, 1023, 0, 1'b0);
        wait_idle();

        // Above the maximum the count is clamped; a long chain makes the walks deep.
        write_node_count(11'd2047);
        for (int i = 0; i < 8; i++)
            queue_edge(14 + i, i, i + 1, i == 0);
        queue_edge(22, 0, 1023, 1'b0);
        queue_edge(23, 1023, 1022, 1'b0);
        wait_idle();

        // Completion stays set when the node count is raised afterwards.
        write_node_count(11'd3);
        queue_edge(24, 0, 1, 1'b1);
        queue_edge(25, 1, 2, 1'b0);
        wait_idle();
        write_node_count(11'd5);
        queue_edge(26, 3, 4, 1'b0);
        wait_idle();

        target = words_queued + RANDOM_WORDS;
        while (words_queued < target)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                setting = 11'd0;
            else if (roll == 1)
                setting = 11'd1;
            else if (roll == 2)
                setting = 11'd1023;
            else if (roll == 3)
                setting = 11'd1024;
            else if (roll == 4)
                setting = 11'd2047;
            else if (roll == 5)
                setting = ufe_pkg::NCOUNT_W'($urandom_range(0, 2047));
            else
                setting = ufe_pkg::NCOUNT_W'($urandom_range(2, 40));
            write_node_count(setting);
            span = clamp_nodes(setting);
            steady = ($urandom_range(0, 3) == 0);
            graphs = $urandom_range(1, 3);
            for (int g = 0; g < graphs; g++)
            begin
                chain = ($urandom_range(0, 3) == 0);
                count = $urandom_range(4, 50);
                base = $urandom_range(0, span - 1);
                for (int k = 0; k < count; k++)
                begin
                    fresh = (k == 0) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 49) == 0);
                    roll = $urandom_range(0, 19);
                    if (roll == 0)
                    begin
                        a = $urandom_range(0, 1023);
                        b = $urandom_range(0, 1023);
                    end
                    else if (roll == 1)
                    begin
                        a = $urandom_range(0, span - 1);
                        b = a;
                    end
                    else if (chain && roll < 15)
                    begin
                        a = (base + k) % span;
                        b = (base + k + 1) % span;
                    end
                    else
                    begin
                        a = $urandom_range(0, span - 1);
                        b = $urandom_range(0, span - 1);
                    end
                    queue_edge($urandom_range(0, 65535), a, b, fresh);
                end
            end
            wait_idle();
        end

        repeat (20) @(negedge clk);
        if (fault_count == 0 && expected_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
